[design/multistage_heavy_hitter_table_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the multistage heavy-hitter table
// Concurrent checks on clk; one form honours rst_n, the other runs through it.
// ----------------------------------------------------------------------------
`ifndef MULTISTAGE_HEAVY_HITTER_TABLE_TOP_DEFINES_SVH
`define MULTISTAGE_HEAVY_HITTER_TABLE_TOP_DEFINES_SVH

`ifndef SYNTH

// Check a property on every rising edge outside reset
`define MHH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising edge, reset included
`define MHH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define MHH_ASSERT(lbl, prop, msg)
`define MHH_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[design/mhh_pkg.sv]
// ----------------------------------------------------------------------------
// mhh_pkg
// Shared widths, hash constants, result codes and types of the heavy-hitter
// table.
// ----------------------------------------------------------------------------
`default_nettype none

package mhh_pkg;

    // Fixed geometry and field widths
    localparam int STAGE_COUNT = 4;
    localparam int STAGE_W     = 2;
    localparam int FP_W        = 32;
    localparam int RW_W        = 31;
    localparam int CNT_W       = 32;
    localparam int ACT_W       = 2;
    localparam int PROBE_W     = 3;

    // Slot hash: bits SLOT_SHIFT and up of the 32-bit product
    localparam int SLOT_SHIFT  = 15;
    localparam int HASH_W      = 32 - SLOT_SHIFT;

    localparam logic [31:0] STAGE_MULT [STAGE_COUNT] = '{
        32'h04C1_1DB7, 32'h1EDC_6F41, 32'hA833_982B, 32'h8141_41AB
    };

    // Counts saturate here
    localparam logic [CNT_W-1:0] SAT_COUNT = 32'h8000_0000;

    // Result action codes
    localparam logic [ACT_W-1:0] ACT_CLAIMED     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INCREMENTED = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REPLACED    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_KEPT        = 2'd3;

    // Probe totals when every stage missed
    localparam logic [PROBE_W-1:0] PROBES_ALL      = 3'd4;
    localparam logic [PROBE_W-1:0] PROBES_REPLACED = 3'd5;

    // One table entry: count in the upper word, fingerprint in the lower
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [FP_W-1:0]  key;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SLOT,
        ST_DECIDE,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

[design/mhh_if.sv]
// ----------------------------------------------------------------------------
// mhh_if
// Valid/ready channels of the heavy-hitter table: packet in, result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhh_in_if;
    logic                        valid;
    logic                        ready;
    logic [mhh_pkg::FP_W-1:0]    fingerprint;
    logic [mhh_pkg::RW_W-1:0]    random_word;

    modport source (output valid, output fingerprint, output random_word, input ready);
    modport sink   (input valid, input fingerprint, input random_word, output ready);
endinterface

interface mhh_out_if;
    logic                         valid;
    logic                         ready;
    logic [mhh_pkg::ACT_W-1:0]    action;
    logic [mhh_pkg::STAGE_W-1:0]  stage_hit;
    logic [mhh_pkg::CNT_W-1:0]    entry_count;
    logic [mhh_pkg::PROBE_W-1:0]  probes;

    modport source (output valid, output action, output stage_hit, output entry_count,
                    output probes, input ready);
    modport sink   (input valid, input action, input stage_hit, input entry_count,
                    input probes, output ready);
endinterface

`default_nettype wire

[design/mhh_slot_calc.sv]
// ----------------------------------------------------------------------------
// mhh_slot_calc
// Pipeline that turns a fingerprint into one slot per stage:
// multiplicative hash, then reduction modulo the stage depth by reciprocal
// multiply with a single correction step.
// ----------------------------------------------------------------------------
`default_nettype none

module mhh_slot_calc #(
    parameter  int STAGE_DEPTH = 8192,
    localparam int IDX_W       = $clog2(STAGE_DEPTH)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [mhh_pkg::FP_W-1:0]  fingerprint,
    output logic                      done,
    output logic [IDX_W-1:0]          slot [mhh_pkg::STAGE_COUNT]
);

    localparam int HW = mhh_pkg::HASH_W;
    localparam int SC = mhh_pkg::STAGE_COUNT;

    // floor(2^HW / depth): the quotient estimate is low by at most one
    localparam int              RECIP   = (1 << HW) / STAGE_DEPTH;
    localparam logic [HW-1:0]   RECIP_L = HW'(RECIP);
    localparam logic [HW:0]     DEPTH_L = (HW + 1)'(STAGE_DEPTH);

    logic [4:0]               vld_reg;
    logic [4:0]               vld_next;
    logic [mhh_pkg::FP_W-1:0] fp_reg;
    logic [HW-1:0]            hv_reg    [SC];
    logic [HW-1:0]            hv_next   [SC];
    logic [HW-1:0]            hvd_reg   [SC];
    logic [HW-1:0]            q_reg     [SC];
    logic [HW-1:0]            q_next    [SC];
    logic [HW-1:0]            rest_reg  [SC];
    logic [HW-1:0]            rest_next [SC];
    logic [IDX_W-1:0]         slot_reg  [SC];
    logic [IDX_W-1:0]         slot_next [SC];

    // Advance the stage valid bits
    assign vld_next = {vld_reg[3:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Per-stage arithmetic of each pipeline step
    always_comb
    begin
        logic [31:0]       h;
        logic [2*HW-1:0]   qm;
        logic [2*HW:0]     qd;
        logic [HW:0]       r;
        for (int s = 0; s < SC; s++)
        begin
            h            = fp_reg * mhh_pkg::STAGE_MULT[s];
            hv_next[s]   = h[31:mhh_pkg::SLOT_SHIFT];
            qm           = hv_reg[s] * RECIP_L;
            q_next[s]    = qm[2*HW-1:HW];
            qd           = q_reg[s] * DEPTH_L;
            rest_next[s] = hvd_reg[s] - qd[HW-1:0];
            r            = {1'b0, rest_reg[s]};
            if (r >= DEPTH_L)
            begin
                r = r - DEPTH_L;
            end
            slot_next[s] = r[IDX_W-1:0];
        end
    end

    // Hold each step's data until its valid bit moves it on
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            fp_reg <= fingerprint;
        end
        for (int s = 0; s < SC; s++)
        begin
            if (vld_reg[0])
            begin
                hv_reg[s] <= hv_next[s];
            end
            if (vld_reg[1])
            begin
                q_reg[s]   <= q_next[s];
                hvd_reg[s] <= hv_reg[s];
            end
            if (vld_reg[2])
            begin
                rest_reg[s] <= rest_next[s];
            end
            if (vld_reg[3])
            begin
                slot_reg[s] <= slot_next[s];
            end
        end
    end

    assign done = vld_reg[4];
    assign slot = slot_reg;

endmodule

`default_nettype wire

[design/multistage_heavy_hitter_table_top.sv]
// ----------------------------------------------------------------------------
// multistage_heavy_hitter_table_top
// Four-stage heavy-hitter table held in four single-port-read banks; each
// packet claims, increments or probabilistically replaces one entry, or none.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  pkt      | in  | valid/ready  | fingerprint[31:0], random_word[30:0]
//  result   | out | valid/ready  | action[1:0], stage_hit[1:0],
//           |     |              | entry_count[31:0], probes[2:0]
//
//  Each packet passes from acceptance to its result register through the
//  slot pipeline, a registered bank read, a registered decision and the
//  write-back. The read-modify-write of the banks keeps one packet in
//  flight at a time.
//  After reset the banks are swept to zero, one row a cycle, across all
//  STAGE_DEPTH rows with pkt.ready low.
//  A stalled result holds in its register; the next packet is taken
//  meanwhile and waits at write-back until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multistage_heavy_hitter_table_top_defines.svh"

module multistage_heavy_hitter_table_top #(
    parameter  int STAGE_DEPTH = 8192,
    localparam int IDX_W       = $clog2(STAGE_DEPTH)
) (
    input  logic       clk,
    input  logic       rst_n,
    mhh_in_if.sink     pkt,
    mhh_out_if.source  result
);

    localparam int SC = mhh_pkg::STAGE_COUNT;
    localparam int SW = mhh_pkg::STAGE_W;

    mhh_pkg::state_t state_reg;
    mhh_pkg::state_t state_next;
    logic [IDX_W-1:0] clr_addr_reg;
    logic [IDX_W-1:0] clr_addr_next;

    logic [mhh_pkg::FP_W-1:0] fp_reg;
    logic [mhh_pkg::RW_W-1:0] rw_reg;

    logic             slot_start;
    logic             slot_done;
    logic [IDX_W-1:0] slot [SC];

    logic                rd_en;
    mhh_pkg::entry_t     rd_data_reg [SC];
    logic [SC-1:0]       bank_we;
    logic [IDX_W-1:0]    bank_waddr [SC];
    mhh_pkg::entry_t     bank_wdata;

    logic                          dec_hit_reg;
    logic                          dec_hit_next;
    logic [mhh_pkg::ACT_W-1:0]     dec_act_reg;
    logic [mhh_pkg::ACT_W-1:0]     dec_act_next;
    logic [SW-1:0]                 dec_stage_reg;
    logic [SW-1:0]                 dec_stage_next;
    logic [mhh_pkg::CNT_W-1:0]     dec_cnt_reg;
    logic [mhh_pkg::CNT_W-1:0]     dec_cnt_next;
    logic [mhh_pkg::PROBE_W-1:0]   dec_probes_reg;
    logic [mhh_pkg::PROBE_W-1:0]   dec_probes_next;

    logic [mhh_pkg::CNT_W-1:0]     ceil_mask;
    logic [mhh_pkg::CNT_W-1:0]     ceil_cnt;
    logic                          replace;
    logic                          fin_write;
    logic [mhh_pkg::ACT_W-1:0]     fin_act;
    logic [mhh_pkg::CNT_W-1:0]     fin_cnt;
    logic [mhh_pkg::PROBE_W-1:0]   fin_probes;
    logic                          fire;

    logic                          out_valid_reg;
    logic [mhh_pkg::ACT_W-1:0]     out_act_reg;
    logic [SW-1:0]                 out_stage_reg;
    logic [mhh_pkg::CNT_W-1:0]     out_cnt_reg;
    logic [mhh_pkg::PROBE_W-1:0]   out_probes_reg;

    // Propagate the highest set bit into every lower position
    function automatic logic [31:0] smear_down(input logic [31:0] v);
        logic [31:0] r;
        r = v;
        r = r | (r >> 1);
        r = r | (r >> 2);
        r = r | (r >> 4);
        r = r | (r >> 8);
        r = r | (r >> 16);
        return r;
    endfunction

    // Slot pipeline
    mhh_slot_calc #(
        .STAGE_DEPTH (STAGE_DEPTH)
    ) u_slot (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (slot_start),
        .fingerprint (pkt.fingerprint),
        .done        (slot_done),
        .slot        (slot)
    );

    // State register and sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mhh_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Sequencer: sweep, accept, hash, read, decide, write back
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        pkt.ready     = 1'b0;
        slot_start    = 1'b0;
        rd_en         = 1'b0;
        case (state_reg)
            mhh_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == IDX_W'(STAGE_DEPTH - 1))
                begin
                    clr_addr_next = '0;
                    state_next    = mhh_pkg::ST_IDLE;
                end
            end
            mhh_pkg::ST_IDLE:
            begin
                pkt.ready = 1'b1;
                if (pkt.valid)
                begin
                    slot_start = 1'b1;
                    state_next = mhh_pkg::ST_SLOT;
                end
            end
            mhh_pkg::ST_SLOT:
            begin
                if (slot_done)
                begin
                    rd_en      = 1'b1;
                    state_next = mhh_pkg::ST_DECIDE;
                end
            end
            mhh_pkg::ST_DECIDE:
            begin
                state_next = mhh_pkg::ST_FINISH;
            end
            mhh_pkg::ST_FINISH:
            begin
                if (fire)
                begin
                    state_next = mhh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mhh_pkg::ST_CLEAR;
            end
        endcase
    end

    // Capture the packet
    always_ff @(posedge clk)
    begin
        if (pkt.valid && pkt.ready)
        begin
            fp_reg <= pkt.fingerprint;
            rw_reg <= pkt.random_word;
        end
    end

    // Table banks: one read port, one write port each
    for (genvar g = 0; g < SC; g++)
    begin : g_bank
        mhh_pkg::entry_t mem [STAGE_DEPTH];

        always_ff @(posedge clk)
        begin
            if (bank_we[g])
            begin
                mem[bank_waddr[g]] <= bank_wdata;
            end
            if (rd_en)
            begin
                rd_data_reg[g] <= mem[slot[g]];
            end
        end
    end

    // Decide: first empty or matching stage, else the smallest count
    always_comb
    begin
        logic                      hit;
        logic                      hit_empty;
        logic [SW-1:0]             hit_stage;
        logic [mhh_pkg::CNT_W-1:0] hit_old;
        logic [mhh_pkg::CNT_W-1:0] min_cnt;
        logic [SW-1:0]             min_stage;
        hit       = 1'b0;
        hit_empty = 1'b0;
        hit_stage = '0;
        for (int s = SC - 1; s >= 0; s--)
        begin
            if ((rd_data_reg[s].count == '0) || (rd_data_reg[s].key == fp_reg))
            begin
                hit       = 1'b1;
                hit_empty = (rd_data_reg[s].count == '0);
                hit_stage = SW'(s);
            end
        end
        hit_old   = rd_data_reg[hit_stage].count;
        min_cnt   = rd_data_reg[0].count;
        min_stage = '0;
        for (int s = 1; s < SC; s++)
        begin
            if (rd_data_reg[s].count < min_cnt)
            begin
                min_cnt   = rd_data_reg[s].count;
                min_stage = SW'(s);
            end
        end

        dec_hit_next    = hit;
        dec_probes_next = mhh_pkg::PROBE_W'(hit_stage) + 1'b1;
        if (!hit)
        begin
            dec_act_next   = mhh_pkg::ACT_KEPT;
            dec_stage_next = min_stage;
            dec_cnt_next   = min_cnt;
        end
        else if (hit_empty)
        begin
            dec_act_next   = mhh_pkg::ACT_CLAIMED;
            dec_stage_next = hit_stage;
            dec_cnt_next   = mhh_pkg::CNT_W'(1);
        end
        else
        begin
            dec_act_next   = mhh_pkg::ACT_INCREMENTED;
            dec_stage_next = hit_stage;
            dec_cnt_next   = (hit_old < mhh_pkg::SAT_COUNT) ? hit_old + 1'b1 : hit_old;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == mhh_pkg::ST_DECIDE)
        begin
            dec_hit_reg    <= dec_hit_next;
            dec_act_reg    <= dec_act_next;
            dec_stage_reg  <= dec_stage_next;
            dec_cnt_reg    <= dec_cnt_next;
            dec_probes_reg <= dec_probes_next;
        end
    end

    // Write-back: power-of-two ceiling and the replacement draw
    always_comb
    begin
        ceil_mask = smear_down(dec_cnt_reg - 1'b1);
        ceil_cnt  = ceil_mask + 1'b1;
        replace   = ((rw_reg & ceil_mask[mhh_pkg::RW_W-1:0]) == '0);
        if (dec_hit_reg)
        begin
            fin_write  = 1'b1;
            fin_act    = dec_act_reg;
            fin_cnt    = dec_cnt_reg;
            fin_probes = dec_probes_reg;
        end
        else if (replace)
        begin
            fin_write  = 1'b1;
            fin_act    = mhh_pkg::ACT_REPLACED;
            fin_cnt    = ceil_cnt;
            fin_probes = mhh_pkg::PROBES_REPLACED;
        end
        else
        begin
            fin_write  = 1'b0;
            fin_act    = mhh_pkg::ACT_KEPT;
            fin_cnt    = dec_cnt_reg;
            fin_probes = mhh_pkg::PROBES_ALL;
        end
    end

    assign fire = (state_reg == mhh_pkg::ST_FINISH) && (!out_valid_reg || result.ready);

    // Bank write steering: the sweep writes every bank, a packet at most one
    always_comb
    begin
        for (int s = 0; s < SC; s++)
        begin
            if (state_reg == mhh_pkg::ST_CLEAR)
            begin
                bank_we[s]    = 1'b1;
                bank_waddr[s] = clr_addr_reg;
            end
            else
            begin
                bank_we[s]    = fire && fin_write && (dec_stage_reg == SW'(s));
                bank_waddr[s] = slot[s];
            end
        end
        if (state_reg == mhh_pkg::ST_CLEAR)
        begin
            bank_wdata = '0;
        end
        else
        begin
            bank_wdata.count = fin_cnt;
            bank_wdata.key   = fp_reg;
        end
    end

    // Result register: hold the transaction until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_act_reg    <= fin_act;
            out_stage_reg  <= dec_stage_reg;
            out_cnt_reg    <= fin_cnt;
            out_probes_reg <= fin_probes;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.action      = out_act_reg;
    assign result.stage_hit   = out_stage_reg;
    assign result.entry_count = out_cnt_reg;
    assign result.probes      = out_probes_reg;

    // Checks
    `MHH_ASSERT(a_accept_starts_slot, (pkt.valid && pkt.ready) |=> (state_reg == mhh_pkg::ST_SLOT), "accepted packet did not start the slot pipeline")
    `MHH_ASSERT(a_single_bank_write, (state_reg != mhh_pkg::ST_CLEAR) |-> $onehot0(bank_we), "more than one bank written for a packet")
    `MHH_ASSERT(a_slot_in_range, slot_done |-> ((32'(slot[0]) < STAGE_DEPTH) && (32'(slot[1]) < STAGE_DEPTH) && (32'(slot[2]) < STAGE_DEPTH) && (32'(slot[3]) < STAGE_DEPTH)), "slot beyond stage depth")
    `MHH_ASSERT(a_count_bounded, result.valid |-> (result.entry_count <= mhh_pkg::SAT_COUNT), "entry count above saturation")
    `MHH_ASSERT(a_replace_probes, (result.valid && (result.action == mhh_pkg::ACT_REPLACED)) |-> (result.probes == mhh_pkg::PROBES_REPLACED), "replacement with wrong probe total")
    `MHH_ASSERT_ALWAYS(a_quiet_in_reset, !rst_n |-> (!pkt.ready && !result.valid), "handshake active during reset")

endmodule

`default_nettype wire

[sim/tb_multistage_heavy_hitter_table_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multistage_heavy_hitter_table_top
// Drives packets into the heavy-hitter table and checks every result against
// a local model of the four-stage table. A short stimulus table covers zero
// and all-ones fingerprints, claims, increments, kept and replaced minima.
// Random traffic follows, mostly flows that share slots in every stage, with
// random idling on both channels and one long result back-pressure window.
// ----------------------------------------------------------------------------

module tb_multistage_heavy_hitter_table_top;

    localparam int STAGE_DEPTH   = 8192;
    localparam int RANDOM_ITEMS  = 400;
    localparam int FLOW_GROUPS   = 6;
    localparam int IDLE_PERCENT  = 38;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 200000;

    // One result transaction
    typedef struct packed {
        logic [mhh_pkg::ACT_W-1:0]   action;
        logic [mhh_pkg::STAGE_W-1:0] stage_hit;
        logic [mhh_pkg::CNT_W-1:0]   entry_count;
        logic [mhh_pkg::PROBE_W-1:0] probes;
    } outcome_t;

    // One row of the directed stimulus table
    typedef struct packed {
        logic [mhh_pkg::FP_W-1:0] fingerprint;
        logic [mhh_pkg::RW_W-1:0] random_word;
        logic                     typed;
        outcome_t                 want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 24;

    // Fingerprints differing only above bit 27 share a slot in every stage
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{32'h0000_0000, 31'h0000_0000, 1'b1,
          '{mhh_pkg::ACT_CLAIMED, 2'd0, 32'd1, 3'd1}},
        '{32'h0000_0000, 31'h7FFF_FFFF, 1'b1,
          '{mhh_pkg::ACT_INCREMENTED, 2'd0, 32'd2, 3'd1}},
        '{32'h1000_0000, 31'h7FFF_FFFF, 1'b1,
          '{mhh_pkg::ACT_CLAIMED, 2'd1, 32'd1, 3'd2}},
        '{32'h2000_0000, 31'h2AAA_AAAA, 1'b1,
          '{mhh_pkg::ACT_CLAIMED, 2'd2, 32'd1, 3'd3}},
        '{32'h3000_0000, 31'h5555_5555, 1'b1,
          '{mhh_pkg::ACT_CLAIMED, 2'd3, 32'd1, 3'd4}},
        '{32'h4000_0000, 31'h7FFF_FFFF, 1'b1,
          '{mhh_pkg::ACT_REPLACED, 2'd1, 32'd1, mhh_pkg::PROBES_REPLACED}},
        '{32'h4000_0000, 31'h0000_0000, 1'b1,
          '{mhh_pkg::ACT_INCREMENTED, 2'd1, 32'd2, 3'd2}},
        '{32'h5000_0000, 31'h0000_0001, 1'b1,
          '{mhh_pkg::ACT_REPLACED, 2'd2, 32'd1, mhh_pkg::PROBES_REPLACED}},
        '{32'h5000_0000, 31'h0000_0001, 1'b1,
          '{mhh_pkg::ACT_INCREMENTED, 2'd2, 32'd2, 3'd3}},
        '{32'h6000_0000, 31'h0000_0001, 1'b1,
          '{mhh_pkg::ACT_REPLACED, 2'd3, 32'd1, mhh_pkg::PROBES_REPLACED}},
        '{32'h6000_0000, 31'h0000_0001, 1'b1,
          '{mhh_pkg::ACT_INCREMENTED, 2'd3, 32'd2, 3'd4}},
        '{32'h7000_0000, 31'h0000_0001, 1'b1,
          '{mhh_pkg::ACT_KEPT, 2'd0, 32'd2, mhh_pkg::PROBES_ALL}},
        '{32'h7000_0000, 31'h7FFF_FFFE, 1'b1,
          '{mhh_pkg::ACT_REPLACED, 2'd0, 32'd2, mhh_pkg::PROBES_REPLACED}},
        '{32'h7000_0000, 31'h0000_0000, 1'b1,
          '{mhh_pkg::ACT_INCREMENTED, 2'd0, 32'd3, 3'd1}},
        '{32'h8000_0000, 31'h0000_0003, 1'b1,
          '{mhh_pkg::ACT_KEPT, 2'd1, 32'd2, mhh_pkg::PROBES_ALL}},
        '{32'h4000_0000, 31'h1234_5678, 1'b0, '0},
        '{32'h5000_0000, 31'h0765_4321, 1'b0, '0},
        '{32'h6000_0000, 31'h7FFF_FFFF, 1'b0, '0},
        '{32'h8000_0000, 31'h0000_0002, 1'b1,
          '{mhh_pkg::ACT_KEPT, 2'd0, 32'd3, mhh_pkg::PROBES_ALL}},
        '{32'h8000_0000, 31'h7FFF_FFFC, 1'b1,
          '{mhh_pkg::ACT_REPLACED, 2'd0, 32'd4, mhh_pkg::PROBES_REPLACED}},
        '{32'hFFFF_FFFF, 31'h0000_0000, 1'b1,
          '{mhh_pkg::ACT_CLAIMED, 2'd0, 32'd1, 3'd1}},
        '{32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1,
          '{mhh_pkg::ACT_INCREMENTED, 2'd0, 32'd2, 3'd1}},
        '{32'h0FFF_FFFF, 31'h0000_0000, 1'b0, '0},
        '{32'h1234_5678, 31'h4000_0000, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    mhh_in_if  pkt_bus ();
    mhh_out_if result_bus ();

    multistage_heavy_hitter_table_top #(
        .STAGE_DEPTH (STAGE_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pkt    (pkt_bus),
        .result (result_bus)
    );

    // Local copy of the flow table and the outcomes still owed by the block
    mhh_pkg::entry_t flow_table [mhh_pkg::STAGE_COUNT][STAGE_DEPTH];
    outcome_t        pending_outcomes [$];

    int  mismatch_count = 0;
    int  packets_sent   = 0;
    int  cycle_count    = 0;
    bit  steady         = 1'b0;
    bit  hold_result    = 1'b0;

    // Clock: 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clear the local table, hold reset, then release it
    initial
    begin
        rst_n                  = 1'b0;
        pkt_bus.valid          = 1'b0;
        pkt_bus.fingerprint    = '0;
        pkt_bus.random_word    = '0;
        result_bus.ready       = 1'b0;
        for (int s = 0; s < mhh_pkg::STAGE_COUNT; s++)
        begin
            for (int i = 0; i < STAGE_DEPTH; i++)
            begin
                flow_table[s][i] = '0;
            end
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_multistage_heavy_hitter_table_top NOT OK");
            $finish;
        end
    end

    // Smallest power of two not below a count, capped at the saturation value
    function automatic logic [mhh_pkg::CNT_W-1:0] count_ceiling(
        input logic [mhh_pkg::CNT_W-1:0] count);
        logic [mhh_pkg::CNT_W-1:0] ceil2;
        ceil2 = 32'd1;
        while (ceil2 < count && ceil2 < mhh_pkg::SAT_COUNT)
        begin
            ceil2 = ceil2 << 1;
        end
        return ceil2;
    endfunction

    // Apply one packet to the local table and return the outcome it causes
    function automatic outcome_t tally_packet(input logic [mhh_pkg::FP_W-1:0] fp,
                                              input logic [mhh_pkg::RW_W-1:0] rw);
        outcome_t                  res;
        logic [31:0]               prod;
        logic [mhh_pkg::CNT_W-1:0] cnt;
        logic [mhh_pkg::CNT_W-1:0] min_cnt;
        logic [mhh_pkg::CNT_W-1:0] ceil2;
        int                        slot;
        int                        min_slot;
        int                        min_stage;
        int                        s;
        min_cnt   = '0;
        min_slot  = 0;
        min_stage = 0;
        for (s = 0; s < mhh_pkg::STAGE_COUNT; s++)
        begin
            prod = fp * mhh_pkg::STAGE_MULT[s];
            slot = int'((prod >> mhh_pkg::SLOT_SHIFT) % STAGE_DEPTH);
            cnt  = flow_table[s][slot].count;
            // Empty entry: claim it
            if (cnt == '0)
            begin
                flow_table[s][slot] = '{count: 32'd1, key: fp};
                res = '{mhh_pkg::ACT_CLAIMED, mhh_pkg::STAGE_W'(s), 32'd1,
                        mhh_pkg::PROBE_W'(s + 1)};
                return res;
            end
            // Same flow: advance, holding at saturation
            if (flow_table[s][slot].key == fp)
            begin
                if (cnt < mhh_pkg::SAT_COUNT)
                begin
                    cnt = cnt + 1;
                end
                flow_table[s][slot].count = cnt;
                res = '{mhh_pkg::ACT_INCREMENTED, mhh_pkg::STAGE_W'(s), cnt,
                        mhh_pkg::PROBE_W'(s + 1)};
                return res;
            end
            // Track the smallest count, first stage on ties
            if (s == 0 || cnt < min_cnt)
            begin
                min_cnt   = cnt;
                min_slot  = slot;
                min_stage = s;
            end
        end
        // Every stage missed: try to take over the minimum
        ceil2 = count_ceiling(min_cnt);
        if ((rw & mhh_pkg::RW_W'(ceil2 - 1)) == '0)
        begin
            flow_table[min_stage][min_slot] = '{count: ceil2, key: fp};
            res = '{mhh_pkg::ACT_REPLACED, mhh_pkg::STAGE_W'(min_stage), ceil2,
                    mhh_pkg::PROBES_REPLACED};
        end
        else
        begin
            res = '{mhh_pkg::ACT_KEPT, mhh_pkg::STAGE_W'(min_stage), min_cnt,
                    mhh_pkg::PROBES_ALL};
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    // Offer one packet, idling at random first; log its outcome on acceptance
    task automatic offer_packet(input logic [mhh_pkg::FP_W-1:0] fp,
                                input logic [mhh_pkg::RW_W-1:0] rw,
                                input logic typed, input outcome_t want);
        outcome_t predicted;
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            pkt_bus.valid <= 1'b0;
            @(posedge clk);
        end
        pkt_bus.valid       <= 1'b1;
        pkt_bus.fingerprint <= fp;
        pkt_bus.random_word <= rw;
        @(posedge clk);
        while (!pkt_bus.ready)
        begin
            @(posedge clk);
        end
        predicted = tally_packet(fp, rw);
        pending_outcomes.push_back(typed ? want : predicted);
        packets_sent++;
    endtask

    // Stimulus: directed table, pause until drained, then random traffic
    initial
    begin
        logic [27:0]              flow_base [FLOW_GROUPS];
        logic [31:0]              word;
        logic [mhh_pkg::FP_W-1:0] fp;
        logic [mhh_pkg::RW_W-1:0] rw;
        int                       pick;
        for (int g = 0; g < FLOW_GROUPS; g++)
        begin
            word         = $urandom;
            flow_base[g] = word[27:0];
        end
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end

        // Walk the directed table
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            offer_packet(DIRECTED[r].fingerprint, DIRECTED[r].random_word,
                         DIRECTED[r].typed, DIRECTED[r].want);
        end

        // Drop valid and let every outstanding transaction return
        pkt_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0)
        begin
            @(posedge clk);
        end

        // Random traffic, mostly flows colliding in all four stages
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                fp = {4'($urandom_range(7)), flow_base[$urandom_range(FLOW_GROUPS - 1)]};
            end
            else
            begin
                fp = $urandom;
            end
            word = $urandom;
            pick = $urandom_range(9);
            if (pick < 4)
            begin
                rw = '0;
            end
            else if (pick < 7)
            begin
                pick = $urandom_range(6);
                rw   = (word[mhh_pkg::RW_W-1:0] >> pick) << pick;
            end
            else
            begin
                rw = word[mhh_pkg::RW_W-1:0];
            end
            offer_packet(fp, rw, 1'b0, '0);
        end
        pkt_bus.valid <= 1'b0;

        // Wait for the last transactions, then watch for strays
        @(posedge clk);
        while (pending_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb_multistage_heavy_hitter_table_top OK");
        end
        else
        begin
            $display("tb_multistage_heavy_hitter_table_top NOT OK");
        end
        $finish;
    end

    // Pacing: one long result hold-off, then a stretch with no idling
    initial
    begin
        while (packets_sent < 120)
        begin
            @(negedge clk);
        end
        hold_result = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_result = 1'b0;
        while (packets_sent < 250)
        begin
            @(negedge clk);
        end
        steady = 1'b1;
        while (packets_sent < 330)
        begin
            @(negedge clk);
        end
        steady = 1'b0;
    end

    // Result side: check each transaction, then drive ready for the next cycle
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                report_mismatch("unexpected result, entry_count", 32'd0,
                                result_bus.entry_count);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (result_bus.action !== want.action)
                begin
                    report_mismatch("action", 32'(want.action), 32'(result_bus.action));
                end
                if (result_bus.stage_hit !== want.stage_hit)
                begin
                    report_mismatch("stage_hit", 32'(want.stage_hit),
                                    32'(result_bus.stage_hit));
                end
                if (result_bus.entry_count !== want.entry_count)
                begin
                    report_mismatch("entry_count", want.entry_count, result_bus.entry_count);
                end
                if (result_bus.probes !== want.probes)
                begin
                    report_mismatch("probes", 32'(want.probes), 32'(result_bus.probes));
                end
            end
        end
        if (hold_result)
        begin
            result_bus.ready <= 1'b0;
        end
        else if (steady)
        begin
            result_bus.ready <= 1'b1;
        end
        else
        begin
            result_bus.ready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

endmodule

[sim.f]
+incdir+design
design/mhh_pkg.sv
design/mhh_if.sv
design/mhh_slot_calc.sv
design/multistage_heavy_hitter_table_top.sv
sim/tb_multistage_heavy_hitter_table_top.sv
